// ===== rtl/core/nec_pkg.sv =====
`timescale 1ns / 1ps
package nec_pkg;

  localparam logic [7:0]  ALAW_XOR   = 8'hD5;
  localparam logic [15:0] ALAW_CLIP  = 16'd32635;
  localparam logic [15:0] STEP_RESET = 16'd13107;

  typedef enum logic [0:0] {
    REG_STEP_SIZE = 1'b0,
    REG_DT_ENABLE = 1'b1
  } reg_idx_t;

  // G.711 A-law code to 16-bit linear
  function automatic logic signed [15:0] alaw_dec(input logic [7:0] code);
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [15:0] mag;
    a   = code ^ ALAW_XOR;
    seg = a[6:4];
    mag = {8'd0, a[3:0], 4'd8};
    if (seg != 3'd0) mag = mag + 16'd256;
    if (seg > 3'd1) mag = mag << (seg - 3'd1);
    return a[7] ? -$signed(mag) : $signed(mag);
  endfunction

  // 16-bit linear to G.711 A-law code, magnitude clipped to 32635
  function automatic logic [7:0] alaw_enc(input logic signed [15:0] pcm);
    logic        sgn;
    logic [15:0] mag;
    logic [15:0] sh;
    logic [2:0]  seg;
    logic [3:0]  mant;
    sgn = pcm[15];
    mag = sgn ? 16'(-pcm) : 16'(pcm);
    if (mag > ALAW_CLIP) mag = ALAW_CLIP;
    seg = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mag[i + 7]) seg = 3'(i);
    end
    // widen the shift amount so segments 5..7 do not wrap
    sh   = (seg == 3'd0) ? (mag >> 4) : (mag >> (4'(seg) + 4'd3));
    mant = sh[3:0];
    return {sgn, seg, mant} ^ ALAW_XOR;
  endfunction

endpackage

// ===== rtl/core/nec_div.sv =====
`timescale 1ns / 1ps
module nec_div #(
  parameter int NW = 64,
  parameter int DW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  import nec_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
        quo_r <= {quo_r[NW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without running");
endmodule

// ===== rtl/core/nlms_echo_canceller_alaw.sv =====
`timescale 1ns / 1ps
// One item at a time. When the weights are updated, an item takes one filter pass and one update pass over
// the tap memories at one tap per cycle plus the serial divider at one quotient bit per cycle; when the
// update is skipped, it takes the filter pass only. A waiting result adds its stall.
// The result is registered; the next item is taken while it waits.
// Reset (synchronous, rst_n low) clears all per-channel state and then sweeps every entry of
// the history and weight memories, zeroing them; no input is taken meanwhile.
module nlms_echo_canceller_alaw #(
  parameter int TAPS     = 50,
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] far_byte, [15:8] near_byte
  input  logic [0:0]  in_tuser,   // [0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [0:0]  out_tuser,  // [0] adapted
  input  logic        cfg_we,
  input  nec_pkg::reg_idx_t cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import nec_pkg::*;

  localparam int DEPTH = CHANNELS * TAPS;
  localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(TAPS);
  localparam int KW    = $clog2(TAPS + 1);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WCW   = $clog2(TAPS + 2);
  localparam int EW    = 30 + $clog2(TAPS + 1);
  localparam int ACW   = 48 + $clog2(TAPS);
  localparam int YW    = ACW - 30;
  localparam int EEW   = YW + 1;
  localparam int NMW   = 16 + EEW;
  localparam int NW    = NMW + 20;
  localparam logic [45:0] GLIM = 46'h2000_0000_0000;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDOLD, S_SQOLD, S_ENERGY, S_FIR,
    S_ERR, S_MUL, S_GATE, S_DIV, S_UPD, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] step_r;
  logic        dte_r;

  logic [EW-1:0]  energy_r [CHANNELS];
  logic [WCW-1:0] warm_r   [CHANNELS];
  logic [14:0]    peak_r   [CHANNELS];
  logic [KW-1:0]  age_r    [CHANNELS];
  logic [PW-1:0]  head_r   [CHANNELS];

  logic [15:0] hmem [DEPTH];
  logic [31:0] wmem [DEPTH];

  logic [MAW-1:0] clr_r;
  logic [CHW-1:0] ch_r;
  logic [MAW-1:0] base_r;
  logic [PW-1:0]  pos_r;
  logic [KW-1:0]  k_r;
  logic signed [15:0] far_r;
  logic signed [15:0] near_r;
  logic [14:0] fmag_r;
  logic [14:0] nmag_r;
  logic [29:0] fsq_r;
  logic [29:0] osq_r;
  logic        adapt_r;
  logic        nz_r;
  logic        bad_ch_r;

  logic [15:0] h_rd_r;
  logic [31:0] w_rd_r;
  logic        rv_r;
  logic        pv_r;
  logic        s2v_r;
  logic [MAW-1:0] wa1_r;
  logic [MAW-1:0] wa2_r;
  logic signed [47:0]  fprod_r;
  logic signed [ACW-1:0] acc_r;
  logic signed [EEW-1:0] e_r;
  logic signed [EEW+16:0] nprod_r;
  logic signed [46:0]  g_r;
  logic signed [62:0]  uprod_r;
  logic [31:0]         wold_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_adapt_r;

  logic [MAW-1:0] h_raddr;
  logic [MAW-1:0] w_raddr;
  logic           h_we;
  logic [MAW-1:0] h_waddr;
  logic [15:0]    h_wdata;
  logic           w_we;
  logic [MAW-1:0] w_waddr;
  logic [31:0]    w_wdata;

  logic           div_start;
  logic [NW-1:0]  div_num;
  logic           div_done;
  logic [NW-1:0]  div_quo;
  logic           neg_r;

  logic [CHW-1:0] in_ch;
  logic [PW-1:0]  pos_dec;
  logic           issuing;
  logic           pipe_busy;
  logic signed [ACW-1:0] acc_rnd;
  logic signed [YW-1:0]  y_val;
  logic signed [63:0]    wsum;
  logic [31:0]           wsat;
  logic signed [15:0]    e_sat;
  logic [NMW-1:0]        nmag_w;
  logic [45:0]           gmag;
  logic [14:0]           peak_new;
  logic [EW-1:0]         energy_new;
  logic                  warm_full;

  assign in_ch     = CHW'(in_tuser[0]);
  assign pos_dec   = (pos_r == '0) ? PW'(TAPS - 1) : pos_r - 1'b1;
  assign issuing   = k_r < KW'(TAPS);
  assign pipe_busy = issuing || rv_r || pv_r || s2v_r;
  assign h_raddr   = base_r + MAW'(pos_r);
  assign w_raddr   = base_r + MAW'(k_r);

  assign acc_rnd = acc_r + (ACW'(1) <<< 29);
  assign y_val   = acc_rnd[ACW-1:30];

  assign wsum = {{32{wold_r[31]}}, wold_r} + 64'(uprod_r >>> 5);
  always_comb begin
    if (wsum > 64'sd2147483647)       wsat = 32'h7FFF_FFFF;
    else if (wsum < -64'sd2147483648) wsat = 32'h8000_0000;
    else                              wsat = wsum[31:0];
  end

  always_comb begin
    if (e_r > EEW'(32767))       e_sat = 16'sd32767;
    else if (e_r < -EEW'(32768)) e_sat = -16'sd32768;
    else                         e_sat = e_r[15:0];
  end

  assign nmag_w  = nprod_r[EEW+16] ? NMW'(-nprod_r) : NMW'(nprod_r);
  assign div_num = {nmag_w, 20'd0};
  assign gmag    = (div_quo > NW'(GLIM)) ? GLIM : div_quo[45:0];

  // peak window and energy window for the current channel
  always_comb begin
    if (fmag_r > peak_r[ch_r])            peak_new = fmag_r;
    else if (age_r[ch_r] < KW'(TAPS))     peak_new = peak_r[ch_r];
    else                                  peak_new = fmag_r;
  end
  assign warm_full  = warm_r[ch_r] >= WCW'(TAPS);
  assign energy_new = (warm_full ? energy_r[ch_r] - EW'(osq_r) : energy_r[ch_r])
                      + EW'(fsq_r);

  // memory write ports
  always_comb begin
    h_we    = 1'b0;
    h_waddr = h_raddr;
    h_wdata = far_r;
    w_we    = 1'b0;
    w_waddr = wa2_r;
    w_wdata = wsat;
    if (state_r == S_CLEAR) begin
      h_we    = 1'b1;
      h_waddr = clr_r;
      h_wdata = '0;
      w_we    = 1'b1;
      w_waddr = clr_r;
      w_wdata = '0;
    end else begin
      h_we = (state_r == S_ENERGY);
      w_we = (state_r == S_UPD) && s2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    h_rd_r <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= w_wdata;
    w_rd_r <= wmem[w_raddr];
  end

  assign div_start = (state_r == S_GATE) && adapt_r && nz_r;

  nec_div #(.NW(NW), .DW(EW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (energy_r[ch_r]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      dte_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_SIZE: step_r <= cfg_wdata;
        REG_DT_ENABLE: dte_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      pv_r        <= 1'b0;
      s2v_r       <= 1'b0;
      k_r         <= KW'(TAPS);
      for (int c = 0; c < CHANNELS; c++) begin
        energy_r[c] <= '0;
        warm_r[c]   <= '0;
        peak_r[c]   <= '0;
        age_r[c]    <= '0;
        head_r[c]   <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;

      // shared tap pipeline: issue, read data, product, accumulate or write back
      rv_r <= (state_r == S_FIR || state_r == S_UPD) && issuing;
      if ((state_r == S_FIR || state_r == S_UPD) && issuing) begin
        k_r   <= k_r + 1'b1;
        pos_r <= pos_dec;
        wa1_r <= w_raddr;
      end
      pv_r  <= rv_r && (state_r == S_FIR);
      s2v_r <= rv_r && (state_r == S_UPD);
      if (rv_r) begin
        fprod_r <= $signed(w_rd_r) * $signed(h_rd_r);
        uprod_r <= g_r * $signed(h_rd_r);
        wold_r  <= w_rd_r;
        wa2_r   <= wa1_r;
      end
      if (pv_r) acc_r <= acc_r + ACW'(fprod_r);

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MAW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            ch_r     <= in_ch;
            base_r   <= MAW'(in_ch) * MAW'(TAPS);
            far_r    <= alaw_dec(in_tdata[7:0]);
            near_r   <= alaw_dec(in_tdata[15:8]);
            bad_ch_r <= int'(in_tuser[0]) >= CHANNELS;
            if (int'(in_tuser[0]) >= CHANNELS) begin
              e_r     <= '0;
              adapt_r <= 1'b0;
              state_r <= S_OUT;
            end else begin
              pos_r   <= (head_r[in_ch] == PW'(TAPS - 1)) ? '0 : head_r[in_ch] + 1'b1;
              state_r <= S_RDOLD;
            end
          end
        end
        S_RDOLD: begin
          fmag_r  <= far_r[15] ? 15'(-far_r) : far_r[14:0];
          nmag_r  <= near_r[15] ? 15'(-near_r) : near_r[14:0];
          state_r <= S_SQOLD;
        end
        S_SQOLD: begin
          fsq_r   <= fmag_r * fmag_r;
          osq_r   <= 30'($signed(h_rd_r) * $signed(h_rd_r));
          state_r <= S_ENERGY;
        end
        S_ENERGY: begin
          // oldest entry is overwritten by the new far sample here
          peak_r[ch_r] <= peak_new;
          if (fmag_r > peak_r[ch_r] || age_r[ch_r] >= KW'(TAPS)) age_r[ch_r] <= '0;
          else age_r[ch_r] <= age_r[ch_r] + 1'b1;
          if (!(warm_r[ch_r] > WCW'(TAPS))) warm_r[ch_r] <= warm_r[ch_r] + 1'b1;
          energy_r[ch_r] <= energy_new;
          head_r[ch_r]   <= pos_r;
          nz_r    <= energy_new != '0;
          adapt_r <= dte_r ? ({1'b0, nmag_r, 1'b0} < {2'b0, peak_new}) : 1'b1;
          acc_r   <= '0;
          k_r     <= '0;
          state_r <= S_FIR;
        end
        S_FIR: begin
          if (!pipe_busy) state_r <= S_ERR;
        end
        S_ERR: begin
          e_r     <= EEW'(near_r) - EEW'(y_val);
          state_r <= S_MUL;
        end
        S_MUL: begin
          nprod_r <= $signed({1'b0, step_r}) * e_r;
          state_r <= S_GATE;
        end
        S_GATE: begin
          neg_r <= nprod_r[EEW+16];
          pos_r <= head_r[ch_r];
          state_r <= (adapt_r && nz_r) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            g_r     <= neg_r ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
            k_r     <= '0;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (!pipe_busy) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_byte_r  <= alaw_enc(e_sat);
            out_adapt_r <= adapt_r && !bad_ch_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tuser[0] = out_adapt_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second item taken while busy");
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider finished outside divide state");
  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT)) else $error("result loaded out of order");
  a_wb_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    (w_we && state_r != S_CLEAR) |-> state_r == S_UPD) else $error("stray weight write");
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import nec_pkg::*;

  localparam int NTAPS    = 50;
  localparam int NCH      = 2;
  localparam int HOLD_LEN = 2000;
  localparam int WD_LIMIT = 20000;

  typedef struct packed {
    logic       ch;
    logic [7:0] far_code;
    logic [7:0] near_code;
  } sample_t;

  typedef struct packed {
    logic [7:0] code;
    logic       adapted;
  } echo_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] far_byte, [15:8] near_byte
  logic [0:0] in_tuser = '0;    // [0] channel
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;        // [7:0] out_byte
  logic [0:0] out_tuser;        // [0] adapted
  logic cfg_we = 1'b0;
  reg_idx_t cfg_addr = REG_STEP_SIZE;
  logic [15:0] cfg_wdata = '0;

  nlms_echo_canceller_alaw dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // canceller model state
  logic [15:0]        mu_q15;
  logic               dt_gate_on;
  logic signed [15:0] far_hist [NCH][NTAPS];
  logic signed [31:0] tap_wt [NCH][NTAPS];
  longint             win_energy [NCH];
  int                 warm_cnt [NCH];
  int                 peak_mag [NCH];
  int                 peak_cnt [NCH];

  sample_t   pending_samples [$];
  echo_out_t expected_codes [$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_hold = 0;
  bit        no_idle = 0;
  bit        hold_request = 0;
  bit        hold_done = 0;

  function automatic int alaw_to_pcm(input logic [7:0] code);
    logic [7:0] a;
    int seg, mag;
    a   = code ^ 8'hD5;
    seg = int'(a[6:4]);
    mag = (int'(a[3:0]) << 4) + 8;
    if (seg != 0) mag = mag + 256;
    if (seg > 1) mag = mag << (seg - 1);
    return a[7] ? -mag : mag;
  endfunction

  function automatic logic [7:0] pcm_to_alaw(input int pcm);
    logic sgn;
    int mag, seg, mask, mant;
    sgn  = pcm < 0;
    mag  = sgn ? -pcm : pcm;
    seg  = 7;
    mask = 32'h4000;
    if (mag > 32635) mag = 32635;
    while (seg > 0 && (mag & mask) == 0) begin
      seg--;
      mask = mask >> 1;
    end
    mant = (mag >> (seg == 0 ? 4 : seg + 3)) & 15;
    return {sgn, 3'(seg), 4'(mant)} ^ 8'hD5;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic clear_model();
    mu_q15     = 16'd13107;
    dt_gate_on = 1'b1;
    for (int c = 0; c < NCH; c++) begin
      win_energy[c] = 0;
      warm_cnt[c]   = 0;
      peak_mag[c]   = 0;
      peak_cnt[c]   = 0;
      for (int k = 0; k < NTAPS; k++) begin
        far_hist[c][k] = '0;
        tap_wt[c][k]   = '0;
      end
    end
  endtask

  function automatic echo_out_t cancel_echo(input sample_t s);
    echo_out_t r;
    int c, far, near, fmag, nmag;
    longint acc, y, e, num, g, d, old;
    bit adapt;
    c    = int'(s.ch);
    far  = alaw_to_pcm(s.far_code);
    near = alaw_to_pcm(s.near_code);
    fmag = far < 0 ? -far : far;
    nmag = near < 0 ? -near : near;
    if (fmag > peak_mag[c]) begin
      peak_mag[c] = fmag;
      peak_cnt[c] = 0;
    end else if (peak_cnt[c] < NTAPS) begin
      peak_cnt[c]++;
    end else begin
      peak_cnt[c] = 0;
      peak_mag[c] = fmag;
    end
    if (warm_cnt[c] < NTAPS + 1) warm_cnt[c]++;
    if (warm_cnt[c] >= NTAPS + 1) begin
      old = far_hist[c][NTAPS-1];
      win_energy[c] -= old * old;
    end
    win_energy[c] += longint'(far) * far;
    for (int k = NTAPS - 1; k > 0; k--) far_hist[c][k] = far_hist[c][k-1];
    far_hist[c][0] = 16'(far);
    acc = 0;
    for (int k = 0; k < NTAPS; k++) acc += longint'(tap_wt[c][k]) * longint'(far_hist[c][k]);
    y = (acc + (64'sd1 <<< 29)) >>> 30;
    e = near - y;
    adapt = dt_gate_on ? (2 * nmag < peak_mag[c]) : 1'b1;
    if (adapt && win_energy[c] != 0) begin
      num = longint'(mu_q15) * e * (64'sd1 <<< 20);
      g   = clip(num / win_energy[c], -(64'sd1 <<< 45), 64'sd1 <<< 45);
      for (int k = 0; k < NTAPS; k++) begin
        d = (g * longint'(far_hist[c][k])) >>> 5;
        tap_wt[c][k] = 32'(clip(longint'(tap_wt[c][k]) + d,
                                -64'sd2147483648, 64'sd2147483647));
      end
    end
    r.code    = pcm_to_alaw(int'(clip(e, -32768, 32767)));
    r.adapted = adapt;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 6);
    return $urandom_range(20, 250);
  endfunction

  // sender: predict on each transfer, then present the next sample
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_codes.push_back(cancel_echo('{in_tuser[0], in_tdata[7:0], in_tdata[15:8]}));
    end
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {s.near_code, s.far_code};
        in_tuser  <= s.ch;
        send_gap  <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: out_byte=%h adapted=%b", out_tdata, out_tuser[0]);
      end else begin
        echo_out_t x;
        x = expected_codes.pop_front();
        if (x.code !== out_tdata || x.adapted !== out_tuser[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: out_byte exp %h got %h, adapted exp %b got %b",
                     x.code, out_tdata, x.adapted, out_tuser[0]);
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done  <= 1'b1;
      recv_hold  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold  <= recv_hold - 1;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) out_tready <= 1'b1;
      else if (p < 97) out_tready <= 1'b0;
      else begin
        out_tready <= 1'b0;
        recv_hold  <= $urandom_range(20, 250);
      end
    end
  end

  // watchdog: any cycle without a transfer counts toward the limit
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_STEP_SIZE) mu_q15 = val;
    else dt_gate_on = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_tvalid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] quiet_code();
    return {1'($urandom_range(0, 1)), 3'($urandom_range(0, 1)), 4'($urandom_range(0, 15))}
           ^ 8'hD5;
  endfunction

  function automatic logic [7:0] loud_code();
    return {1'($urandom_range(0, 1)), 3'($urandom_range(5, 7)), 4'($urandom_range(0, 15))}
           ^ 8'hD5;
  endfunction

  // mostly loud far with quiet near so the filter adapts; some double talk and noise
  task automatic queue_random(input int n);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      int p;
      p = $urandom_range(0, 99);
      s.ch = 1'($urandom_range(0, 1));
      if (p < 70) begin
        s.far_code  = loud_code();
        s.near_code = quiet_code();
      end else if (p < 85) begin
        s.far_code  = loud_code();
        s.near_code = loud_code();
      end else begin
        s.far_code  = 8'($urandom_range(0, 255));
        s.near_code = 8'($urandom_range(0, 255));
      end
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    logic [7:0] edge_codes [6];
    sample_t s;
    edge_codes = '{8'h00, 8'hFF, 8'hD5, 8'h55, 8'h2A, 8'hAA};
    clear_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: code extremes on both channels, gate pass and fail
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 3; j++) begin
        s.ch        = 1'((i + j) % 2);
        s.far_code  = edge_codes[i];
        s.near_code = edge_codes[(i + j * 2) % 6];
        pending_samples.push_back(s);
      end
    end
    for (int i = 0; i < 6; i++) begin
      s.ch        = 1'(i % 2);
      s.far_code  = loud_code();
      s.near_code = (i < 3) ? quiet_code() : loud_code();
      pending_samples.push_back(s);
    end
    drain();

    write_reg(REG_STEP_SIZE, 16'hFFFF);
    write_reg(REG_DT_ENABLE, {15'($urandom), 1'b1});
    queue_random(130);
    drain();

    write_reg(REG_STEP_SIZE, 16'h0000);
    write_reg(REG_DT_ENABLE, {15'($urandom), 1'b0});
    no_idle = 1;
    queue_random(100);
    drain();
    no_idle = 0;

    write_reg(REG_STEP_SIZE, 16'($urandom));
    write_reg(REG_DT_ENABLE, {15'($urandom), 1'b0});
    queue_random(130);
    hold_request = 1;
    drain();

    write_reg(REG_STEP_SIZE, 16'd13107);
    write_reg(REG_DT_ENABLE, {15'($urandom), 1'b1});
    queue_random(190);
    drain();

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
